// ===== rtl/hbpq_pkg.sv =====
// Shared types, codes and helpers for the binary heap priority queue.
package hbpq_pkg;

    localparam int VALUE_W = 17;
    localparam int LIMIT_W = 11;
    localparam int CFG_DATA_W = 11;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Smallest element that the heap holds; the one pattern below
    // the lower bound is clamped to it.
    localparam value_t VAL_MIN = -17'sd65535;
    localparam value_t VAL_LOW_PATTERN = 17'sh10000;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    typedef enum logic [0:0] {
        REG_HEAP_MODE      = 1'b0,
        REG_CAPACITY_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // True when a must sit strictly above b under the selected ordering.
    function automatic logic ranks_above(input logic mode, input value_t a, input value_t b);
        return (mode == MODE_MIN) ? (a < b) : (a > b);
    endfunction

endpackage

// ===== rtl/hbpq_ram.sv =====
// Single-port-write, single-port-read synchronous memory holding the heap array.
module hbpq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW = 10,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hbpq_ctrl.sv =====
// Sequencer that runs the sift-up and sift-down passes against the heap memory.
module hbpq_ctrl #(
    parameter int CAPACITY = 1024,
    parameter int CNT_W = 11,
    parameter int AW = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            op,
    input  hbpq_pkg::value_t                value,
    input  logic                            heap_mode,
    input  logic [hbpq_pkg::LIMIT_W-1:0]    capacity_limit,
    output logic                            busy,
    output logic                            done,
    output hbpq_pkg::value_t                top_value,
    output hbpq_pkg::status_t               status,
    output logic [CNT_W-1:0]                count,
    output logic                            ram_we,
    output logic [AW-1:0]                   ram_waddr,
    output hbpq_pkg::value_t                ram_wdata,
    output logic                            ram_re,
    output logic [AW-1:0]                   ram_raddr,
    input  hbpq_pkg::value_t                ram_rdata
);
    import hbpq_pkg::*;

    // Positions are 1-based and need one spare bit for the child index 2*p.
    localparam int PW = CNT_W + 1;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_DEL_LAST,
        S_DEL_MOVED,
        S_DEL_LEFT,
        S_DEL_RIGHT,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    child_reg, child_next;
    value_t           item_reg, item_next;
    value_t           left_reg, left_next;
    value_t           top_reg, top_next;
    logic             del_reg, del_next;
    logic             done_reg, done_next;
    status_t          status_reg, status_next;
    value_t           top_value_reg, top_value_next;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p);
        logic [PW-1:0] d;
        d = p - PW'(1);
        return d[AW-1:0];
    endfunction

    logic [PW-1:0] n_ext;
    logic [PW-1:0] parent_pos;
    logic [PW-1:0] chosen_pos;
    logic [PW-1:0] grand_pos;
    logic [PW-1:0] first_pos;
    value_t        chosen_val;
    value_t        sat_value;
    logic          right_wins;
    logic          advance;
    logic          full;
    logic          finish;

    always_comb
    begin
        n_ext = PW'(count_reg);
        parent_pos = pos_reg >> 1;
        right_wins = (state_reg == S_DEL_RIGHT) && ranks_above(heap_mode, ram_rdata, left_reg);
        chosen_val = (state_reg == S_DEL_RIGHT && !right_wins) ? left_reg : ram_rdata;
        chosen_pos = right_wins ? (child_reg + PW'(1)) : child_reg;
        grand_pos = chosen_pos << 1;
        advance = ranks_above(heap_mode, chosen_val, item_reg);
        sat_value = (value == VAL_LOW_PATTERN) ? VAL_MIN : value;
        first_pos = PW'(count_reg) + PW'(1);
        full = (CMP_W'(count_reg) >= CMP_W'(capacity_limit)) || (CMP_W'(count_reg) >= CAP_CMP);

        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        child_next = child_reg;
        item_next = item_reg;
        left_next = left_reg;
        top_next = top_reg;
        del_next = del_reg;
        done_next = 1'b0;
        status_next = status_reg;
        top_value_next = top_value_reg;
        finish = 1'b0;

        ram_we = 1'b0;
        ram_waddr = addr_of(pos_reg);
        ram_wdata = item_reg;
        ram_re = 1'b0;
        ram_raddr = addr_of(pos_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    del_next = op;
                    if (op == OP_INSERT)
                    begin
                        if (full)
                        begin
                            done_next = 1'b1;
                            status_next = STATUS_FULL;
                            top_value_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                            pos_next = first_pos;
                            item_next = sat_value;
                            if (count_reg != '0)
                            begin
                                ram_re = 1'b1;
                                ram_raddr = addr_of(first_pos >> 1);
                                state_next = S_INS_CMP;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next = 1'b1;
                            status_next = STATUS_EMPTY;
                            top_value_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                            ram_re = 1'b1;
                            ram_raddr = '0;
                            state_next = S_DEL_LAST;
                        end
                    end
                end
            end

            S_INS_CMP:
            begin
                ram_we = 1'b1;
                if (ranks_above(heap_mode, item_reg, ram_rdata))
                begin
                    // Parent moves down; the read of the next parent overlaps the write.
                    ram_wdata = ram_rdata;
                    pos_next = parent_pos;
                    if (parent_pos > PW'(1))
                    begin
                        ram_re = 1'b1;
                        ram_raddr = addr_of(parent_pos >> 1);
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            S_DEL_LAST:
            begin
                top_next = ram_rdata;
                ram_re = 1'b1;
                ram_raddr = count_reg[AW-1:0];
                state_next = S_DEL_MOVED;
            end

            S_DEL_MOVED:
            begin
                item_next = ram_rdata;
                pos_next = PW'(1);
                if (n_ext >= PW'(2))
                begin
                    child_next = PW'(2);
                    ram_re = 1'b1;
                    ram_raddr = addr_of(PW'(2));
                    state_next = S_DEL_LEFT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_DEL_LEFT, S_DEL_RIGHT:
            begin
                if (state_reg == S_DEL_LEFT && child_reg != n_ext)
                begin
                    // A right sibling exists; fetch it before choosing.
                    left_next = ram_rdata;
                    ram_re = 1'b1;
                    ram_raddr = child_reg[AW-1:0];
                    state_next = S_DEL_RIGHT;
                end
                else if (advance)
                begin
                    ram_we = 1'b1;
                    ram_wdata = chosen_val;
                    pos_next = chosen_pos;
                    if (grand_pos <= n_ext)
                    begin
                        child_next = grand_pos;
                        ram_re = 1'b1;
                        ram_raddr = addr_of(grand_pos);
                        state_next = S_DEL_LEFT;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                    finish = 1'b1;
                end
            end

            S_FIN:
            begin
                ram_we = 1'b1;
                finish = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next = 1'b1;
            status_next = STATUS_OK;
            top_value_next = (del_reg == OP_DELETE) ? top_reg : '0;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pos_reg <= '0;
            child_reg <= '0;
            item_reg <= '0;
            left_reg <= '0;
            top_reg <= '0;
            del_reg <= OP_INSERT;
            done_reg <= 1'b0;
            status_reg <= STATUS_OK;
            top_value_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg <= pos_next;
            child_reg <= child_next;
            item_reg <= item_next;
            left_reg <= left_next;
            top_reg <= top_next;
            del_reg <= del_next;
            done_reg <= done_next;
            status_reg <= status_next;
            top_value_reg <= top_value_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign top_value = top_value_reg;
    assign status = status_reg;
    assign count = count_reg;

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// Binary heap priority queue: configuration registers, sequencer and heap memory.
//
// Usage: raise start with op and value while busy is low; the command is taken
// at that clock edge. op selects insert or delete-top. Each command gives one
// result: done is high for exactly one cycle with top_value, status and count
// valid in that cycle. The receiver cannot hold results off.
// Sequence: a refused command (insert when full, delete when empty) answers in
// the next cycle. An insert reads the parent of the new position, if any, then
// moves each parent down while the new value ranks above it, reading the next
// parent alongside, and finally writes the new value. A delete fetches the root
// and the last element, then for each level descended reads the children one
// after the other, because both come through the single read port of the
// memory, and moves the chosen child up; the moved element is written last.
// busy drops in the cycle that done is high, so the next command can be taken
// then. The configuration port (cfg_we, cfg_index, cfg_data) writes heap_mode
// or capacity_limit, as cfg_index selects, and is meant for use while busy is low.
// Reset empties the queue, selects max-heap order and a limit of 1024; the
// memory itself is not cleared, since only written entries are ever read.
module binary_heap_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               op,
    input  hbpq_pkg::value_t                   value,
    output logic                               done,
    output hbpq_pkg::value_t                   top_value,
    output hbpq_pkg::status_t                  status,
    output logic [$clog2(CAPACITY+1)-1:0]      count,
    input  logic                               cfg_we,
    input  hbpq_pkg::reg_index_t               cfg_index,
    input  logic [hbpq_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hbpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic               heap_mode_reg;
    logic [LIMIT_W-1:0] capacity_limit_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    value_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    value_t        ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_mode_reg <= MODE_MAX;
            capacity_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEAP_MODE:
                begin
                    heap_mode_reg <= cfg_data[0];
                end
                REG_CAPACITY_LIMIT:
                begin
                    capacity_limit_reg <= cfg_data[LIMIT_W-1:0];
                end
                default:
                begin
                    heap_mode_reg <= heap_mode_reg;
                end
            endcase
        end
    end

    hbpq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .AW       (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .op             (op),
        .value          (value),
        .heap_mode      (heap_mode_reg),
        .capacity_limit (capacity_limit_reg),
        .busy           (busy),
        .done           (done),
        .top_value      (top_value),
        .status         (status),
        .count          (count),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    hbpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== tb/sv/tb_binary_heap_priority_queue.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the binary heap priority queue: command driver, result monitor, heap predictor.
module tb_binary_heap_priority_queue;

    import hbpq_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    typedef struct {
        logic   op;
        value_t val;
    } command_t;

    typedef struct {
        value_t             top;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   op = OP_INSERT;
    value_t                 value = '0;
    logic                   done;
    value_t                 top_value;
    status_t                status;
    logic [COUNT_W-1:0]     count;
    logic                   cfg_we = 1'b0;
    reg_index_t             cfg_index = REG_HEAP_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predicted heap contents and registers.
    value_t             heap_image [1:CAPACITY];
    int                 held = 0;
    logic               heap_order = MODE_MAX;
    logic [LIMIT_W-1:0] cap_limit = LIMIT_RESET;

    command_t pending_cmds [$];
    outcome_t expected_results [$];
    int       idle_pct = 0;
    int       errors = 0;

    binary_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .value(value),
        .done(done),
        .top_value(top_value),
        .status(status),
        .count(count),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic outranks(value_t a, value_t b);
        return (heap_order == MODE_MIN) ? (a < b) : (a > b);
    endfunction

    // Applies one command to the heap image and returns the result it must give.
    function automatic outcome_t apply_command(logic cmd_op, value_t raw);
        outcome_t res;
        value_t   v;
        value_t   moved;
        int       idx;
        int       child;
        int       eff_cap;
        v = (raw == VAL_LOW_PATTERN) ? VAL_MIN : raw;
        eff_cap = (int'(cap_limit) < CAPACITY) ? int'(cap_limit) : CAPACITY;
        res.top = '0;
        res.status = STATUS_OK;
        if (cmd_op == OP_INSERT) begin
            if (held >= eff_cap) begin
                res.status = STATUS_FULL;
            end
            else begin
                held++;
                idx = held;
                while (idx > 1 && outranks(v, heap_image[idx / 2])) begin
                    heap_image[idx] = heap_image[idx / 2];
                    idx = idx / 2;
                end
                heap_image[idx] = v;
            end
        end
        else if (held == 0) begin
            res.status = STATUS_EMPTY;
        end
        else begin
            res.top = heap_image[1];
            moved = heap_image[held];
            held--;
            idx = 1;
            while (idx * 2 <= held) begin
                child = idx * 2;
                if (child != held && outranks(heap_image[child + 1], heap_image[child]))
                    child++;
                if (!outranks(heap_image[child], moved))
                    break;
                heap_image[idx] = heap_image[child];
                idx = child;
            end
            heap_image[idx] = moved;
        end
        res.count = held[COUNT_W-1:0];
        return res;
    endfunction

    // Command driver: holds start until the transfer happens, then maybe idles.
    always @(posedge clk) begin
        command_t next_cmd;
        logic     launch;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            launch = 1'b0;
            if (start && !busy)
                expected_results.push_back(apply_command(op, value));
            if (start && busy) begin
                launch = 1'b1;
            end
            else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_cmd = pending_cmds.pop_front();
                op <= next_cmd.op;
                value <= next_cmd.val;
                launch = 1'b1;
            end
            start <= launch;
        end
    end

    // Result monitor.
    always @(posedge clk) begin
        outcome_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result with no command outstanding: top_value %0d status %0d count %0d",
                       top_value, status, count);
                errors++;
            end
            else begin
                want = expected_results.pop_front();
                if (top_value !== want.top) begin
                    $error("top_value mismatch: expected %0d, got %0d", want.top, top_value);
                    errors++;
                end
                if (status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (count !== want.count) begin
                    $error("count mismatch: expected %0d, got %0d", want.count, count);
                    errors++;
                end
            end
        end
    end

    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0: v = 17'sh0FFFF;
                    1: v = VAL_MIN;
                    2: v = VAL_LOW_PATTERN;
                    3: v = '0;
                    default: v = -17'sd1;
                endcase
            end
            // A narrow range makes ties between parent and child common.
            1, 2: v = value_t'($urandom_range(8)) - 17'sd4;
            default: v = value_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic add_cmd(logic cmd_op, value_t v);
        command_t c;
        c.op = cmd_op;
        c.val = v;
        pending_cmds.push_back(c);
    endtask

    // Waits until every queued command has been taken and answered.
    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HEAP_MODE)
            heap_order = data[0];
        else
            cap_limit = data[LIMIT_W-1:0];
    endtask

    task automatic set_mode(logic mode);
        logic [CFG_DATA_W-1:0] bits;
        // Upper bits of the mode write are don't-care and get random values.
        bits = CFG_DATA_W'($urandom_range(2047));
        bits[0] = mode;
        write_reg(REG_HEAP_MODE, bits);
    endtask

    initial begin
        logic               ph_mode [7] = '{MODE_MAX, MODE_MIN, MODE_MAX, MODE_MIN,
                                            MODE_MAX, MODE_MIN, MODE_MAX};
        int                 ph_limit [7] = '{1024, 3, 0, 2047, 1024, 1, 5};
        int                 ph_idle [7] = '{0, 47, 0, 23, 47, 0, 23};
        int                 ph_items [7] = '{200, 150, 40, 1100, 150, 60, 60};
        int                 ph_insert [7] = '{60, 30, 50, 98, 40, 50, 50};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: extremes, the clamped pattern, ties, drain past empty.
        add_cmd(OP_DELETE, 17'sh1FFFF);
        add_cmd(OP_INSERT, 17'sh0FFFF);
        add_cmd(OP_INSERT, VAL_MIN);
        add_cmd(OP_INSERT, VAL_LOW_PATTERN);
        add_cmd(OP_INSERT, 17'sd0);
        add_cmd(OP_INSERT, 17'sd7);
        add_cmd(OP_INSERT, 17'sd7);
        add_cmd(OP_INSERT, -17'sd1);
        add_cmd(OP_INSERT, 17'sd1);
        add_cmd(OP_INSERT, 17'sh0FFFF);
        repeat (10) add_cmd(OP_DELETE, 17'sd0);
        wait_quiet();

        // Min order with a tiny limit: refused inserts and ties at the root.
        set_mode(MODE_MIN);
        write_reg(REG_CAPACITY_LIMIT, 11'd2);
        add_cmd(OP_INSERT, 17'sd5);
        add_cmd(OP_INSERT, 17'sd5);
        add_cmd(OP_INSERT, -17'sd3);
        repeat (3) add_cmd(OP_DELETE, 17'sh10000);
        wait_quiet();

        // Random phases; the heap carries over, so mode and limit change while it holds data.
        for (int p = 0; p < 7; p++) begin
            set_mode(ph_mode[p]);
            write_reg(REG_CAPACITY_LIMIT, CFG_DATA_W'(ph_limit[p]));
            idle_pct = ph_idle[p];
            for (int n = 0; n < ph_items[p]; n++) begin
                if ($urandom_range(99) < ph_insert[p])
                    add_cmd(OP_INSERT, pick_value());
                else
                    add_cmd(OP_DELETE, pick_value());
            end
            wait_quiet();
        end

        repeat (40) @(posedge clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("binary_heap_priority_queue test passed");
        else
            $display("binary_heap_priority_queue test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("binary_heap_priority_queue test failed");
        $finish;
    end

endmodule

// ===== binary_heap_priority_queue.f =====
rtl/hbpq_pkg.sv
rtl/hbpq_ram.sv
rtl/hbpq_ctrl.sv
rtl/binary_heap_priority_queue.sv
tb/sv/tb_binary_heap_priority_queue.sv
